[design/rac_pkg.sv]
`default_nettype none

package rac_pkg;

    // reorder window and field widths
    localparam int WINDOW     = 64;
    localparam int POS_W      = $clog2(WINDOW);
    localparam int KIND_W     = 3;
    localparam int INDEX_W    = 32;
    localparam int BYTES_W    = 40;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 7;
    localparam int MAKERS_W   = 32;
    localparam int OWED_W     = 48;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 48;

    localparam logic [BYTES_W-1:0] MIN_CHARGE = BYTES_W'(64'd16777216);

    localparam logic [COUNT_W-1:0] DEPTH_LIMIT_RESET = COUNT_W'(4);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_BUDGET = CFG_IDX_W'(1);

    typedef enum logic [KIND_W-1:0] {
        KIND_RESERVE = 3'd0,
        KIND_PUSH    = 3'd1,
        KIND_DONE    = 3'd2,
        KIND_CLAIM   = 3'd3,
        KIND_SETTLE  = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_REFUSED   = 3'd1,
        STAT_WAIT      = 3'd2,
        STAT_EXHAUSTED = 3'd3,
        STAT_BAD_INDEX = 3'd4,
        STAT_HELD_BACK = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RELEASE,
        S_READ,
        S_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic rel_step;
        logic capture;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic push_ok;
        logic claim_hit;
        logic release_hit;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[design/rac_ifs.sv]
`default_nettype none

interface rac_req_if;
    import rac_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [INDEX_W-1:0]   seq_num;
    logic [BYTES_W-1:0]   byte_count;

    modport source (output valid, output kind, output seq_num, output byte_count,
                    input ready);
    modport sink   (input valid, input kind, input seq_num, input byte_count,
                    output ready);
endinterface

interface rac_rsp_if;
    import rac_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [INDEX_W-1:0]   claimed_index;
    logic [BYTES_W-1:0]   claimed_charge;
    logic [COUNT_W-1:0]   released_count;

    modport source (output valid, output status, output claimed_index,
                    output claimed_charge, output released_count, input ready);
    modport sink   (input valid, input status, input claimed_index,
                    input claimed_charge, input released_count, output ready);
endinterface

interface rac_cfg_if;
    import rac_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[design/rac_ram.sv]
`default_nettype none

module rac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/rac_dp.sv]
`default_nettype none

module rac_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire rac_pkg::dp_cmd_t                   cmd,
    output rac_pkg::dp_stat_t                       stat,
    input  wire logic                               cfg_we,
    input  wire logic [rac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rac_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [rac_pkg::KIND_W-1:0]         in_kind,
    input  wire logic [rac_pkg::INDEX_W-1:0]        in_index,
    input  wire logic [rac_pkg::BYTES_W-1:0]        in_bytes,
    input  wire logic                               out_ready,
    output logic                                    out_valid,
    output logic [rac_pkg::STATUS_W-1:0]            out_status,
    output logic [rac_pkg::INDEX_W-1:0]             out_index,
    output logic [rac_pkg::BYTES_W-1:0]             out_charge,
    output logic [rac_pkg::COUNT_W-1:0]             out_released
);
    import rac_pkg::*;

    // configuration
    logic [COUNT_W-1:0]  depth_limit_reg, depth_limit_next;
    logic [OWED_W-1:0]   byte_budget_reg, byte_budget_next;

    // controller state
    logic [INDEX_W-1:0]  next_release_reg, next_release_next;
    logic [INDEX_W-1:0]  ready_head_reg, ready_head_next;
    logic [COUNT_W-1:0]  active_slots_reg, active_slots_next;
    logic [MAKERS_W-1:0] active_makers_reg, active_makers_next;
    logic [COUNT_W-1:0]  held_count_reg, held_count_next;
    logic [OWED_W-1:0]   owed_bytes_reg, owed_bytes_next;
    logic                stream_done_reg, stream_done_next;
    logic [WINDOW-1:0]   slot_valid_reg, slot_valid_next;

    // item and result
    logic [KIND_W-1:0]   kind_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [BYTES_W-1:0]  bytes_reg;
    status_t             res_status_reg, res_status_next;
    logic [INDEX_W-1:0]  res_index_reg, res_index_next;
    logic [BYTES_W-1:0]  res_charge_reg, res_charge_next;
    logic [COUNT_W-1:0]  res_released_reg, res_released_next;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [BYTES_W-1:0]  out_charge_reg;
    logic [COUNT_W-1:0]  out_released_reg;

    logic [POS_W-1:0]    item_pos;
    logic [POS_W-1:0]    rel_pos;
    logic [POS_W-1:0]    head_pos;
    logic                push_bad;
    logic                ready_nonempty;
    logic [BYTES_W-1:0]  charge;
    logic [OWED_W:0]     owed_sum;
    logic [OWED_W-1:0]   owed_add;
    logic [OWED_W-1:0]   owed_sub;
    logic [COUNT_W-1:0]  depth_eff;
    logic                ram_wr_en;
    logic                ram_rd_en;
    logic [BYTES_W-1:0]  ram_rd_data;

    assign item_pos = index_reg[POS_W-1:0];
    assign rel_pos  = next_release_reg[POS_W-1:0];
    assign head_pos = ready_head_reg[POS_W-1:0];

    assign push_bad = (index_reg < next_release_reg)
                   || ((index_reg - ready_head_reg) >= INDEX_W'(WINDOW))
                   || slot_valid_reg[item_pos];
    assign ready_nonempty = (ready_head_reg != next_release_reg);

    assign charge   = (bytes_reg > MIN_CHARGE) ? bytes_reg : MIN_CHARGE;
    assign owed_sum = {1'b0, owed_bytes_reg} + (OWED_W+1)'(charge);
    assign owed_add = owed_sum[OWED_W] ? '1 : owed_sum[OWED_W-1:0];
    assign owed_sub = (owed_bytes_reg >= OWED_W'(bytes_reg))
                    ? owed_bytes_reg - OWED_W'(bytes_reg) : '0;
    assign depth_eff = (owed_bytes_reg >= byte_budget_reg) ? COUNT_W'(1) : depth_limit_reg;

    assign stat.push_ok     = (kind_reg == KIND_PUSH) && !push_bad;
    assign stat.claim_hit   = (kind_reg == KIND_CLAIM) && ready_nonempty;
    assign stat.release_hit = slot_valid_reg[rel_pos];
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign ram_wr_en = cmd.exec && stat.push_ok;
    assign ram_rd_en = cmd.exec && stat.claim_hit;

    rac_ram #(
        .WIDTH (BYTES_W),
        .DEPTH (WINDOW)
    ) u_charge_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (item_pos),
        .wr_data (charge),
        .rd_en   (ram_rd_en),
        .rd_addr (head_pos),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        depth_limit_next   = depth_limit_reg;
        byte_budget_next   = byte_budget_reg;
        next_release_next  = next_release_reg;
        ready_head_next    = ready_head_reg;
        active_slots_next  = active_slots_reg;
        active_makers_next = active_makers_reg;
        held_count_next    = held_count_reg;
        owed_bytes_next    = owed_bytes_reg;
        stream_done_next   = stream_done_reg;
        slot_valid_next    = slot_valid_reg;
        res_status_next    = res_status_reg;
        res_index_next     = res_index_reg;
        res_charge_next    = res_charge_reg;
        res_released_next  = res_released_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEPTH_LIMIT: depth_limit_next = cfg_data[COUNT_W-1:0];
                CFG_BYTE_BUDGET: byte_budget_next = cfg_data[OWED_W-1:0];
                default: ;
            endcase
        end

        if (cmd.exec)
        begin
            res_status_next   = STAT_OK;
            res_index_next    = '0;
            res_charge_next   = '0;
            res_released_next = '0;
            case (kind_reg)
                KIND_RESERVE:
                begin
                    if (stream_done_reg || (active_slots_reg >= depth_eff))
                    begin
                        res_status_next = STAT_REFUSED;
                    end
                    else
                    begin
                        active_slots_next  = active_slots_reg + COUNT_W'(1);
                        active_makers_next = active_makers_reg + MAKERS_W'(1);
                    end
                end
                KIND_PUSH:
                begin
                    if (push_bad)
                    begin
                        res_status_next = STAT_BAD_INDEX;
                    end
                    else
                    begin
                        owed_bytes_next = owed_add;
                        if (active_makers_reg != '0)
                        begin
                            active_makers_next = active_makers_reg - MAKERS_W'(1);
                        end
                        slot_valid_next[item_pos] = 1'b1;
                        held_count_next = held_count_reg + COUNT_W'(1);
                    end
                end
                KIND_DONE:
                begin
                    stream_done_next = 1'b1;
                    if (active_slots_reg != '0)
                    begin
                        active_slots_next = active_slots_reg - COUNT_W'(1);
                    end
                    if (active_makers_reg != '0)
                    begin
                        active_makers_next = active_makers_reg - MAKERS_W'(1);
                    end
                end
                KIND_CLAIM:
                begin
                    if (ready_nonempty)
                    begin
                        res_index_next  = ready_head_reg;
                        ready_head_next = ready_head_reg + INDEX_W'(1);
                        if (active_slots_reg != '0)
                        begin
                            active_slots_next = active_slots_reg - COUNT_W'(1);
                        end
                    end
                    else if (stream_done_reg && (active_makers_reg == '0))
                    begin
                        res_status_next = (held_count_reg != '0) ? STAT_HELD_BACK
                                                                 : STAT_EXHAUSTED;
                    end
                    else
                    begin
                        res_status_next = STAT_WAIT;
                    end
                end
                KIND_SETTLE:
                begin
                    owed_bytes_next = owed_sub;
                end
                default:
                begin
                    res_status_next = STAT_REFUSED;
                end
            endcase
        end

        if (cmd.rel_step)
        begin
            slot_valid_next[rel_pos] = 1'b0;
            if (held_count_reg != '0)
            begin
                held_count_next = held_count_reg - COUNT_W'(1);
            end
            next_release_next = next_release_reg + INDEX_W'(1);
            res_released_next = res_released_reg + COUNT_W'(1);
        end

        if (cmd.capture)
        begin
            res_charge_next = ram_rd_data;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_limit_reg   <= DEPTH_LIMIT_RESET;
            byte_budget_reg   <= '1;
            next_release_reg  <= '0;
            ready_head_reg    <= '0;
            active_slots_reg  <= '0;
            active_makers_reg <= '0;
            held_count_reg    <= '0;
            owed_bytes_reg    <= '0;
            stream_done_reg   <= 1'b0;
            slot_valid_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            depth_limit_reg   <= depth_limit_next;
            byte_budget_reg   <= byte_budget_next;
            next_release_reg  <= next_release_next;
            ready_head_reg    <= ready_head_next;
            active_slots_reg  <= active_slots_next;
            active_makers_reg <= active_makers_next;
            held_count_reg    <= held_count_next;
            owed_bytes_reg    <= owed_bytes_next;
            stream_done_reg   <= stream_done_next;
            slot_valid_reg    <= slot_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= in_kind;
            index_reg <= in_index;
            bytes_reg <= in_bytes;
        end
        res_status_reg   <= res_status_next;
        res_index_reg    <= res_index_next;
        res_charge_reg   <= res_charge_next;
        res_released_reg <= res_released_next;
        if (cmd.out_load)
        begin
            out_status_reg   <= res_status_reg;
            out_index_reg    <= res_index_reg;
            out_charge_reg   <= res_charge_reg;
            out_released_reg <= res_released_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_index    = out_index_reg;
    assign out_charge   = out_charge_reg;
    assign out_released = out_released_reg;

    // held count tracks the held flags exactly
    a_held_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_valid_reg) == int'(held_count_reg))
        else $error("held count out of step with held flags");

    // released but unclaimed jobs never span more than the window
    a_ready_span: assert property (@(posedge clk) disable iff (!rst_n)
        (next_release_reg - ready_head_reg) <= INDEX_W'(WINDOW))
        else $error("ready span exceeds window");

    // a result is only loaded when the output register can take it
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwrote a pending beat");

endmodule

`default_nettype wire

[design/rac_ctrl.sv]
`default_nettype none

module rac_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire rac_pkg::dp_stat_t stat,
    output rac_pkg::dp_cmd_t       cmd
);
    import rac_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.push_ok)
                begin
                    state_next = S_RELEASE;
                end
                else if (stat.claim_hit)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_RELEASE:
            begin
                if (stat.release_hit)
                begin
                    cmd.rel_step = 1'b1;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/read_ahead_reorder_credit_ctrl.sv]
// channel   role    payload
// req       sink    kind, seq_num, byte_count
// rsp       source  status, claimed_index, claimed_charge, released_count
// cfg       sink    index, data (register write, always ready)
//
// one item at a time, each taken in the idle state and executed: reserve, done, settle,
// unknown kinds, a claim with nothing ready and a refused push go on to the finish state,
// a claim that hits first passes a read state for the registered charge memory read,
// an accepted push the release walk first, which steps the window once a cycle
// the output register holds a finished beat so the next item is taken while it waits
// rsp stalls only hold the controller in its finish state; reset clears all flags at once
`default_nettype none

module read_ahead_reorder_credit_ctrl (
    input wire logic   clk,
    input wire logic   rst_n,
    rac_req_if.sink    req,
    rac_rsp_if.source  rsp,
    rac_cfg_if.sink    cfg
);
    import rac_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     cfg_we;

    // config writes land straight in the datapath registers
    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;

    // controller: sequences load, execute, release walk, charge read, hand-off
    rac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath: counters, held flags, charge memory, result and output registers
    rac_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .in_kind      (req.kind),
        .in_index     (req.seq_num),
        .in_bytes     (req.byte_count),
        .out_ready    (rsp.ready),
        .out_valid    (rsp.valid),
        .out_status   (rsp.status),
        .out_index    (rsp.claimed_index),
        .out_charge   (rsp.claimed_charge),
        .out_released (rsp.released_count)
    );

endmodule

`default_nettype wire
